// File: design/fla_pkg.sv
// Shared types and constants for the LIFO free-list slot allocator.
// No dependencies; used by fla_ctrl and free_list_entry_allocator.
package fla_pkg;

	localparam int INDEX_W  = 10;
	localparam int FREE_W   = 11;
	localparam int STATUS_W = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Result of one request as decided at accept time.
	typedef struct packed {
		status_t             status;
		logic                from_stack;  // granted slot comes from the RAM read
		logic [INDEX_W-1:0]  granted;     // fresh slot, or zero
		logic [FREE_W-1:0]   free_count;
	} result_t;

endpackage

// File: design/fla_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module fla_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: design/fla_ctrl.sv
// Stack pointer and fresh-slot counter of the allocator, with RAM access control.
// Depends on fla_pkg.
module fla_ctrl #(
	parameter int POOL_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              opcode,
	input  logic [fla_pkg::INDEX_W-1:0]       release_index,
	output logic                              ram_en,
	output logic                              ram_we,
	output logic [$clog2(POOL_DEPTH)-1:0]     ram_addr,
	output fla_pkg::result_t                  res
);

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);

	logic [CW-1:0] rc_q, rc_d;
	logic [CW-1:0] nf_q, nf_d;
	logic [CW-1:0] free_now, free_after;
	logic          en_d, we_d;

	assign free_now   = rc_q + (CW'(POOL_DEPTH) - nf_q);
	assign free_after = rc_d + (CW'(POOL_DEPTH) - nf_d);

	always_comb begin
		rc_d           = rc_q;
		nf_d           = nf_q;
		en_d           = 1'b0;
		we_d           = 1'b0;
		ram_addr       = AW'(rc_q);
		res.status     = fla_pkg::ST_OK;
		res.from_stack = 1'b0;
		res.granted    = '0;
		case (opcode)
			fla_pkg::OP_ALLOC: begin
				if (rc_q != '0) begin
					// pop the most recently released slot
					rc_d           = rc_q - CW'(1);
					ram_addr       = AW'(rc_q - CW'(1));
					en_d           = 1'b1;
					res.from_stack = 1'b1;
				end else if (nf_q < CW'(POOL_DEPTH)) begin
					res.granted = fla_pkg::INDEX_W'(nf_q);
					nf_d        = nf_q + CW'(1);
				end else begin
					res.status = fla_pkg::ST_EMPTY;
				end
			end
			fla_pkg::OP_RELEASE: begin
				if (32'(release_index) >= POOL_DEPTH) begin
					res.status = fla_pkg::ST_RANGE;
				end else if (free_now >= CW'(POOL_DEPTH)) begin
					res.status = fla_pkg::ST_FULL;
				end else begin
					// push as new head
					en_d = 1'b1;
					we_d = 1'b1;
					rc_d = rc_q + CW'(1);
				end
			end
			default: begin
				res.status = fla_pkg::ST_OK;
			end
		endcase
		res.free_count = fla_pkg::FREE_W'(free_after);
	end

	assign ram_en = accept & en_d;
	assign ram_we = accept & we_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			nf_q <= '0;
		end else if (accept) begin
			rc_q <= rc_d;
			nf_q <= nf_d;
		end
	end

endmodule

// File: design/free_list_entry_allocator.sv
// Top level of the LIFO free-list slot allocator: stream ports, result pipeline.
// Depends on fla_pkg, fla_ctrl and fla_ram.
//
//  channel | dir | tdata                       | tuser      | use
//  s_*     | in  | [9:0] release_index         | [0] opcode | allocate / release request
//  m_*     | out | [9:0] granted_index,        | [1:0]      | one result item per request
//          |     | [20:10] free_count          |   status   |
//
// Throughput: one item per cycle unless m_tready stalls the output; m_tvalid follows stage 1.
// Stage 1 waits for the single-port stack RAM read; the output register follows.
// Counters update at accept, so a pop right after a push reads the entry that the
// push wrote; the port serves one access a cycle, no forwarding.
// Reset clears counters and valid flags; the stack RAM itself is never cleared.
// A stalled output holds stage 1; s_tready drops only with both stages full and m_tready low.
module free_list_entry_allocator #(
	parameter int POOL_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fla_pkg::IN_DATA_W-1:0]      s_tdata,   // [9:0] release_index
	input  logic                               s_tuser,   // [0] opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fla_pkg::OUT_DATA_W-1:0]     m_tdata,   // [9:0] granted_index, [20:10] free_count
	output logic [fla_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);

	localparam int AW = $clog2(POOL_DEPTH);

	logic                          accept;
	logic                          s1_adv;
	logic                          ram_en;
	logic                          ram_we;
	logic [AW-1:0]                 ram_addr;
	logic [fla_pkg::INDEX_W-1:0]   ram_rdata;
	logic [fla_pkg::INDEX_W-1:0]   release_index;
	fla_pkg::result_t              res;

	logic                          s1_valid_q;
	fla_pkg::result_t              s1_res_q;
	logic                          out_valid_q;
	fla_pkg::status_t              out_status_q;
	logic [fla_pkg::INDEX_W-1:0]   out_granted_q;
	logic [fla_pkg::FREE_W-1:0]    out_free_q;

	assign release_index = s_tdata[fla_pkg::INDEX_W-1:0];

	// stage 1 moves on when the output register is empty or being drained
	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	fla_ctrl #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.opcode       (s_tuser),
		.release_index(release_index),
		.ram_en       (ram_en),
		.ram_we       (ram_we),
		.ram_addr     (ram_addr),
		.res          (res)
	);

	// read data stays put while stage 1 stalls: no new access can start then
	fla_ram #(
		.WIDTH(fla_pkg::INDEX_W),
		.DEPTH(POOL_DEPTH)
	) u_stack (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(release_index),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_res_q <= res;
		end
		if (s1_adv) begin
			out_status_q  <= s1_res_q.status;
			out_granted_q <= s1_res_q.from_stack ? ram_rdata : s1_res_q.granted;
			out_free_q    <= s1_res_q.free_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_free_q, out_granted_q};

	// an accepted item always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted item missing from stage 1");

	// a blocked stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv && !accept) |=> (s1_valid_q && $stable(s1_res_q)))
		else $error("stage 1 item lost while stalled");

	// only a successful allocate takes its slot from the stack RAM
	a_pop_ok_only: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_res_q.from_stack) |-> (s1_res_q.status == fla_pkg::ST_OK))
		else $error("stack pop flagged on a failed request");

	// the stack RAM is written only for an accepted release
	a_ram_write_release: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (accept && s_tuser == fla_pkg::OP_RELEASE))
		else $error("stack write without an accepted release");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for free_list_entry_allocator: predicts each grant/release
// reply from a shadow copy of the free list and checks every result item in order.
// Depends on fla_pkg and the allocator RTL only.
module testbench;

	localparam int POOL       = 1024;    // pool depth of the instance under test
	localparam int CYCLE_CAP  = 400000;  // hard stop, far above the slowest correct run
	localparam int PRINT_CAP  = 40;      // mismatch lines printed before going quiet

	// One reply as the allocator should produce it.
	typedef struct {
		fla_pkg::status_t             status;
		logic [fla_pkg::INDEX_W-1:0]  granted;
		logic [fla_pkg::FREE_W-1:0]   free_count;
	} reply_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [fla_pkg::IN_DATA_W-1:0]    s_tdata;   // [9:0] release_index
	logic                             s_tuser;   // [0] opcode
	logic                             m_tvalid;
	logic                             m_tready;
	logic [fla_pkg::OUT_DATA_W-1:0]   m_tdata;   // [9:0] granted_index, [20:10] free_count
	logic [fla_pkg::STATUS_W-1:0]     m_tuser;   // [1:0] status

	// Shadow free list: released-slot stack, its depth, and the fresh-slot counter.
	logic [fla_pkg::INDEX_W-1:0]      shadow_stack [POOL];
	int                               shadow_pushed;
	int                               shadow_fresh;

	reply_t                           pending_replies [$];  // replies owed, oldest first
	logic [fla_pkg::INDEX_W-1:0]      held_slots [$];       // slots currently out on loan
	int                               errors;
	int                               requests_sent;
	int                               replies_seen;
	int                               status_tally [4];
	int                               cycle_count;
	bit                               src_steady;            // sender offers back to back
	bit                               sink_steady;           // receiver never stalls on its own
	int                               hold_len;
	int                               hold_token;            // bump to start a long hold-off
	int                               hold_seen;
	int                               stall_left;

	free_list_entry_allocator #(
		.POOL_DEPTH(POOL)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Free slots as the block counts them: released entries plus the untouched fresh range.
	function automatic logic [fla_pkg::FREE_W-1:0] shadow_free();
		return fla_pkg::FREE_W'(shadow_pushed + POOL - shadow_fresh);
	endfunction

	// Apply one request to the shadow free list and return the reply it must produce.
	function automatic reply_t apply_request(logic op, logic [fla_pkg::INDEX_W-1:0] idx);
		reply_t r;
		r.status  = fla_pkg::ST_OK;
		r.granted = '0;
		if (op == fla_pkg::OP_ALLOC) begin
			if (shadow_pushed > 0) begin
				// most recently released slot goes out first
				shadow_pushed--;
				r.granted = shadow_stack[shadow_pushed];
			end else if (shadow_fresh < POOL) begin
				r.granted = fla_pkg::INDEX_W'(shadow_fresh);
				shadow_fresh++;
			end else begin
				r.status = fla_pkg::ST_EMPTY;
			end
		end else begin
			// range check wins over the full-pool check
			if (idx >= POOL) begin
				r.status = fla_pkg::ST_RANGE;
			end else if (shadow_free() >= POOL) begin
				r.status = fla_pkg::ST_FULL;
			end else begin
				shadow_stack[shadow_pushed] = idx;
				shadow_pushed++;
			end
		end
		r.free_count = shadow_free();
		return r;
	endfunction

	// Idle length: mostly short, now and then a long one.
	function automatic int pick_idle();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("cycle %0d: %s mismatch, got %0d expected %0d", cycle_count, what, got,
				want);
	endtask

	// Offer one request, hold it until the handshake, then book its expected reply.
	task automatic send_request(input logic op, input logic [fla_pkg::INDEX_W-1:0] idx);
		int     gap;
		int     j;
		reply_t r;
		gap = (src_steady || $urandom_range(0, 99) < 60) ? 0 : pick_idle();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(fla_pkg::IN_DATA_W - fla_pkg::INDEX_W){1'b0}}, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = apply_request(op, idx);
		pending_replies.push_back(r);
		requests_sent++;
		// keep the loan list in step so that random releases mostly return real loans
		if (r.status == fla_pkg::ST_OK) begin
			if (op == fla_pkg::OP_ALLOC) begin
				held_slots.push_back(r.granted);
			end else begin
				for (j = 0; j < held_slots.size(); j++) begin
					if (held_slots[j] == idx) begin
						held_slots.delete(j);
						break;
					end
				end
			end
		end
	endtask

	// Drop valid and hold the sender until every owed reply has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	// Compare one accepted result item with the oldest owed reply.
	task automatic check_reply();
		reply_t want;
		if (pending_replies.size() == 0) begin
			report("unexpected result item", m_tdata, 0);
			return;
		end
		want = pending_replies.pop_front();
		replies_seen++;
		status_tally[want.status]++;
		if (m_tuser !== want.status)
			report("status", m_tuser, want.status);
		if (m_tdata[fla_pkg::INDEX_W-1:0] !== want.granted)
			report("granted_index", m_tdata[fla_pkg::INDEX_W-1:0], want.granted);
		if (m_tdata[fla_pkg::INDEX_W +: fla_pkg::FREE_W] !== want.free_count)
			report("free_count", m_tdata[fla_pkg::INDEX_W +: fla_pkg::FREE_W],
				want.free_count);
	endtask

	// Receiver: check on each output handshake, then choose the next tready.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_reply();
		if (hold_token != hold_seen) begin
			hold_seen  = hold_token;
			stall_left = hold_len;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
			m_tready <= 1'b0;
			stall_left = pick_idle() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d replies still owed", cycle_count,
				pending_replies.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Hand-picked requests: full-pool rejects right after reset, fresh grants in order,
	// LIFO reuse, index extremes and alternating bit patterns, and a double release.
	task automatic test_directed();
		src_steady = 1'b0;
		send_request(fla_pkg::OP_RELEASE, 10'd0);     // every slot is free: full-pool reject
		send_request(fla_pkg::OP_RELEASE, 10'd1023);
		send_request(fla_pkg::OP_ALLOC, 10'd1023);    // index ignored on allocate, grants 0
		send_request(fla_pkg::OP_ALLOC, 10'd0);       // grants 1
		send_request(fla_pkg::OP_RELEASE, 10'd1023);
		send_request(fla_pkg::OP_ALLOC, 10'd0);       // released slot comes back first
		send_request(fla_pkg::OP_RELEASE, 10'd1);
		send_request(fla_pkg::OP_RELEASE, 10'd0);     // pool back to all free
		send_request(fla_pkg::OP_RELEASE, 10'd682);   // full-pool reject again
		send_request(fla_pkg::OP_ALLOC, 10'd341);
		send_request(fla_pkg::OP_ALLOC, 10'd682);
		send_request(fla_pkg::OP_ALLOC, 10'd0);       // next fresh slot
		send_request(fla_pkg::OP_RELEASE, 10'd682);
		send_request(fla_pkg::OP_RELEASE, 10'd341);
		send_request(fla_pkg::OP_ALLOC, 10'd0);
		send_request(fla_pkg::OP_ALLOC, 10'd0);
		send_request(fla_pkg::OP_RELEASE, 10'd5);     // same slot twice: accepted both times
		send_request(fla_pkg::OP_RELEASE, 10'd5);
		send_request(fla_pkg::OP_ALLOC, 10'd0);
		send_request(fla_pkg::OP_ALLOC, 10'd0);
		wait_drained();
	endtask

	// Mixed traffic in chunks: mostly allocates and returns of loaned slots, with some
	// releases of arbitrary indexes as noise.
	task automatic test_random_traffic(input int count);
		int                          k;
		int                          roll;
		logic [fla_pkg::INDEX_W-1:0] idx;
		for (k = 0; k < count; k++) begin
			if (k % 50 == 0) begin
				src_steady  = ($urandom_range(0, 3) == 0);
				sink_steady <= ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			idx  = fla_pkg::INDEX_W'($urandom_range(0, 1023));
			if (roll < 45) begin
				send_request(fla_pkg::OP_ALLOC, idx);
			end else begin
				if (roll < 85 && held_slots.size() != 0)
					idx = held_slots[$urandom_range(0, held_slots.size() - 1)];
				send_request(fla_pkg::OP_RELEASE, idx);
			end
		end
		wait_drained();
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering, so the
	// pipeline fills and s_tready drops; then let it drain.
	task automatic test_backpressure();
		int                          k;
		logic [fla_pkg::INDEX_W-1:0] idx;
		src_steady = 1'b1;
		sink_steady <= 1'b0;
		hold_len   <= 80;
		hold_token <= hold_token + 1;
		for (k = 0; k < 30; k++) begin
			if (k % 3 == 2 && held_slots.size() != 0) begin
				idx = held_slots[$urandom_range(0, held_slots.size() - 1)];
				send_request(fla_pkg::OP_RELEASE, idx);
			end else begin
				send_request(fla_pkg::OP_ALLOC, fla_pkg::INDEX_W'($urandom_range(0, 1023)));
			end
		end
		wait_drained();
		src_steady = 1'b0;
	endtask

	initial begin
		// drive every input to a known value from time zero
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tuser     <= fla_pkg::OP_ALLOC;
		s_tdata     <= '0;
		m_tready    <= 1'b0;
		sink_steady <= 1'b0;
		hold_len    <= 0;
		hold_token  <= 0;
		hold_seen    = 0;
		stall_left   = 0;
		cycle_count <= 0;
		shadow_pushed = 0;
		shadow_fresh  = 0;
		errors        = 0;
		requests_sent = 0;
		replies_seen  = 0;
		src_steady    = 1'b0;
		foreach (status_tally[i]) status_tally[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(200);
		test_backpressure();
		test_random_traffic(200);

		// all stimulus is in; give the two-stage pipeline time to show any stray item
		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_replies.size() != 0)
			report("replies never delivered", pending_replies.size(), 0);

		$display("%0d requests checked: %0d granted or released, %0d empty-pool, %0d full-pool",
			replies_seen, status_tally[fla_pkg::ST_OK], status_tally[fla_pkg::ST_EMPTY],
			status_tally[fla_pkg::ST_FULL]);
		$display("LIFO reuse, full-pool rejects and mixed traffic under random stalls on both sides");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: free_list_entry_allocator.f
design/fla_pkg.sv
design/fla_ram.sv
design/fla_ctrl.sv
design/free_list_entry_allocator.sv
sim/testbench.sv
